// ----- rtl/mfdp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfdp_pkg
// Shared types, constants and weight widening for the dot-product block.
// ----------------------------------------------------------------------------
package mfdp_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
  localparam int          BF16_SHIFT = 16;

  typedef enum logic [1:0] {
    FMT_HALF   = 2'd0,
    FMT_BF16   = 2'd1,
    FMT_SINGLE = 2'd2,
    FMT_RSVD   = 2'd3
  } wfmt_t;

  typedef enum logic [1:0] {
    ST_MAC,
    ST_DRAIN,
    ST_REDUCE
  } bstate_t;

  typedef struct packed {
    logic [31:0]       w;
    logic [31:0]       act;
    logic [LANE_W-1:0] lane;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              red;
    logic              fin;
    logic [LANE_W-1:0] lane;
  } tag_t;

  function automatic logic [5:0] msb64(input logic [63:0] x);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        s;
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [5:0]  pm;
    logic [3:0]  p;
    logic [23:0] sh;
    logic [31:0] r;
    s  = h[15];
    ex = h[14:10];
    fr = h[9:0];
    pm = msb64({54'b0, fr});
    p  = pm[3:0];
    sh = {14'b0, fr} << (5'd23 - {1'b0, p});
    if (ex == 5'h1F) begin
      r = (fr != '0) ? QNAN : {s, 8'hFF, 23'b0};
    end else if (ex == '0) begin
      if (fr == '0) begin
        r = {s, 31'b0};
      end else begin
        r = {s, 8'({4'b0, p} + 8'd103), sh[22:0]};
      end
    end else begin
      r = {s, 8'({3'b0, ex} + 8'd112), fr, 13'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] widen(input wfmt_t fmt, input logic [31:0] raw);
    logic [31:0] r;
    case (fmt)
      FMT_HALF: r = half_to_single(raw[15:0]);
      FMT_BF16: r = {raw[15:0], 16'b0};
      default:  r = raw;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mfdp_fifo.sv -----
// ----------------------------------------------------------------------------
// mfdp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mfdp_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mfdp_front.sv -----
// ----------------------------------------------------------------------------
// mfdp_front
// Weight format register, weight widening and lane assignment.
// ----------------------------------------------------------------------------
module mfdp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_data,
  input  logic            push,
  input  logic            q_full,
  input  logic [31:0]     weight_bits,
  input  logic [31:0]     activation_bits,
  input  logic            last_element,
  output logic            q_push,
  output mfdp_pkg::item_t q_item
);

  mfdp_pkg::wfmt_t                 weight_format;
  logic [mfdp_pkg::LANE_W-1:0]     lane;
  logic [mfdp_pkg::LANE_W-1:0]     lane_next;

  assign cfg_ready = 1'b1;
  assign q_push    = push && !q_full;

  assign q_item.w    = mfdp_pkg::widen(weight_format, weight_bits);
  assign q_item.act  = activation_bits;
  assign q_item.lane = lane;
  assign q_item.last = last_element;

  always_comb begin
    lane_next = lane;
    if (q_push) begin
      lane_next = last_element ? '0 : lane + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_format <= mfdp_pkg::FMT_HALF;
      lane          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        weight_format <= mfdp_pkg::wfmt_t'(cfg_data);
      end
      lane <= lane_next;
    end
  end

endmodule

// ----- rtl/mfdp_fma.sv -----
// ----------------------------------------------------------------------------
// mfdp_fma
// Seven-stage single-precision fused multiply-add, a*b+c, one RNE rounding.
// ----------------------------------------------------------------------------
module mfdp_fma (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [31:0]    a,
  input  logic [31:0]    b,
  input  logic [31:0]    c,
  input  mfdp_pkg::tag_t in_tag,
  output logic           out_valid,
  output logic [31:0]    res,
  output mfdp_pkg::tag_t out_tag
);

  typedef struct packed {
    logic        spec;
    logic [31:0] val;
    logic        sp;
    logic        sc;
    logic        zc;
  } side_t;

  logic [6:0]     vld;
  mfdp_pkg::tag_t tg [7];
  side_t          sd [7];
  side_t          sd0;

  // stage 1: decode, specials, mantissa product
  logic        sa, sb, sc, sp;
  logic [7:0]  exa, exb, exc;
  logic [22:0] fa, fb, fc;
  logic        za, zb, zc, nan_any;
  logic [23:0] ma, mb, mc;
  logic signed [11:0] ea, eb, ec;

  logic [47:0]        prod1;
  logic signed [11:0] ep1, ec1;
  logic [23:0]        mc1;

  logic [47:0]        prod2;
  logic signed [11:0] ep2, ec2;
  logic [23:0]        mc2;
  logic [5:0]         np2, nc2;

  logic [63:0]        mp3, mcn3;
  logic signed [11:0] ep3, ec3;

  logic               gt;
  logic signed [11:0] diff;
  logic [63:0]        big4, small4;
  logic signed [11:0] eg4;
  logic               sg4;
  logic [6:0]         d4;

  logic [63:0]        mask5, al5;
  logic               eff_sub;
  logic [63:0]        sum5;
  logic signed [11:0] eg5;
  logic               sg5, zero5;

  logic [63:0]        sum6;
  logic signed [11:0] eg6;
  logic               sg6, zero6;
  logic [5:0]         msb6;

  // leading-one position of the sum, registered alongside stage 6
  logic [5:0]         msb_s;
  logic [63:0]        sum6b;
  logic signed [11:0] eg6b;
  logic               sg6b, zero6b;

  logic signed [11:0] lsb_raw, lsb, sh, negsh;
  logic [6:0]         shs;
  logic [127:0]       wide;
  logic [23:0]        q_c;
  logic               half_c, st_c;
  logic [23:0]        q7;
  logic               half7, st7, sg7, zero7;
  logic signed [11:0] lsb7;

  logic               inc;
  logic [24:0]        q25;
  logic signed [11:0] lsbf, biased;
  logic [31:0]        packed_r;

  assign msb_s = mfdp_pkg::msb64(sum6);

  always_comb begin
    sa  = a[31];
    sb  = b[31];
    sc  = c[31];
    sp  = sa ^ sb;
    exa = a[30:23];
    exb = b[30:23];
    exc = c[30:23];
    fa  = a[22:0];
    fb  = b[22:0];
    fc  = c[22:0];
    za  = (exa == '0) && (fa == '0);
    zb  = (exb == '0) && (fb == '0);
    zc  = (exc == '0) && (fc == '0);
    nan_any = ((exa == 8'hFF) && (fa != '0)) || ((exb == 8'hFF) && (fb != '0)) ||
              ((exc == 8'hFF) && (fc != '0));
    ma = {exa != '0, fa};
    mb = {exb != '0, fb};
    mc = {exc != '0, fc};
    ea = (exa == '0) ? -12'sd149 : $signed({4'b0, exa}) - 12'sd150;
    eb = (exb == '0) ? -12'sd149 : $signed({4'b0, exb}) - 12'sd150;
    ec = (exc == '0) ? -12'sd149 : $signed({4'b0, exc}) - 12'sd150;

    sd0.sp   = sp;
    sd0.sc   = sc;
    sd0.zc   = zc;
    sd0.spec = 1'b1;
    sd0.val  = mfdp_pkg::QNAN;
    if (nan_any) begin
      sd0.val = mfdp_pkg::QNAN;
    end else if ((exa == 8'hFF) || (exb == 8'hFF)) begin
      if (za || zb || ((exc == 8'hFF) && (sc != sp))) begin
        sd0.val = mfdp_pkg::QNAN;
      end else begin
        sd0.val = {sp, 8'hFF, 23'b0};
      end
    end else if (exc == 8'hFF) begin
      sd0.val = c;
    end else if (za || zb) begin
      if (zc) begin
        sd0.val = (sp == sc) ? {sp, 31'b0} : 32'h0;
      end else begin
        sd0.val = c;
      end
    end else begin
      sd0.spec = 1'b0;
      sd0.val  = '0;
    end
  end

  // stage 4: order operands by magnitude
  always_comb begin
    gt   = (ep3 > ec3) || ((ep3 == ec3) && (mp3 >= mcn3));
    diff = gt ? (ep3 - ec3) : (ec3 - ep3);
    if (sd[2].zc) begin
      big4   = mp3;
      small4 = '0;
      eg4    = ep3;
      sg4    = sd[2].sp;
      d4     = '0;
    end else begin
      big4   = gt ? mp3 : mcn3;
      small4 = gt ? mcn3 : mp3;
      eg4    = gt ? ep3 : ec3;
      sg4    = gt ? sd[2].sp : sd[2].sc;
      d4     = (diff > 12'sd64) ? 7'd64 : diff[6:0];
    end
  end

  // stage 5: align with sticky, add or subtract
  logic [63:0] big_r, small_r;
  logic [6:0]  d_r;
  logic signed [11:0] eg_r;
  logic        sg_r;

  always_comb begin
    mask5   = (64'd1 << d_r[5:0]) - 64'd1;
    if (d_r[6]) begin
      al5 = 64'd1;
    end else begin
      al5 = (small_r >> d_r[5:0]) | {63'b0, |(small_r & mask5)};
    end
    eff_sub = (sd[3].sp != sd[3].sc) && !sd[3].zc;
    sum5    = eff_sub ? (big_r - al5) : (big_r + al5);
    zero5   = eff_sub && (big_r == al5);
    eg5     = eg_r;
    sg5     = sg_r;
  end

  // stage 7: locate rounding point
  always_comb begin
    lsb_raw = $signed({6'b0, msb6}) + eg6b - 12'sd23;
    lsb     = (lsb_raw < -12'sd149) ? -12'sd149 : lsb_raw;
    sh      = lsb - eg6b;
    negsh   = -sh;
    shs     = (sh > 12'sd65) ? 7'd65 : sh[6:0];
    wide    = {sum6b, 64'b0} >> shs;
    if (sh <= 12'sd0) begin
      q_c    = sum6b[23:0] << negsh[4:0];
      half_c = 1'b0;
      st_c   = 1'b0;
    end else begin
      q_c    = wide[87:64];
      half_c = wide[63];
      st_c   = |wide[62:0];
    end
  end

  // output: round and pack, combinational after stage 7
  always_comb begin
    inc    = half7 && (st7 || q7[0]);
    q25    = {1'b0, q7} + {24'b0, inc};
    lsbf   = lsb7;
    if (q25[24]) begin
      q25  = {1'b0, q25[24:1]};
      lsbf = lsb7 + 12'sd1;
    end
    biased = lsbf + 12'sd150;
    if (q25 == '0) begin
      packed_r = {sg7, 31'b0};
    end else if (q25[23]) begin
      if (biased >= 12'sd255) begin
        packed_r = {sg7, 8'hFF, 23'b0};
      end else begin
        packed_r = {sg7, biased[7:0], q25[22:0]};
      end
    end else begin
      packed_r = {sg7, 8'b0, q25[22:0]};
    end
    if (sd[6].spec) begin
      res = sd[6].val;
    end else if (zero7) begin
      res = 32'h0;
    end else begin
      res = packed_r;
    end
  end

  assign out_valid = vld[6];
  assign out_tag   = tg[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tg[0] <= in_tag;
    sd[0] <= sd0;
    for (int i = 1; i < 7; i++) begin
      tg[i] <= tg[i-1];
      sd[i] <= sd[i-1];
    end

    prod1 <= ma * mb;
    ep1   <= ea + eb;
    mc1   <= zc ? 24'b0 : mc;
    ec1   <= ec;

    prod2 <= prod1;
    ep2   <= ep1;
    mc2   <= mc1;
    ec2   <= ec1;
    np2   <= 6'd61 - mfdp_pkg::msb64({16'b0, prod1});
    nc2   <= 6'd61 - mfdp_pkg::msb64({40'b0, mc1});

    mp3   <= {16'b0, prod2} << np2;
    mcn3  <= {40'b0, mc2} << nc2;
    ep3   <= ep2 - $signed({6'b0, np2});
    ec3   <= ec2 - $signed({6'b0, nc2});

    big_r   <= big4;
    small_r <= small4;
    eg_r    <= eg4;
    sg_r    <= sg4;
    d_r     <= d4;

    sum6  <= sum5;
    eg6   <= eg5;
    sg6   <= sg5;
    zero6 <= zero5;

    msb6   <= msb_s;
    sum6b  <= sum6;
    eg6b   <= eg6;
    sg6b   <= sg6;
    zero6b <= zero6;

    q7    <= q_c;
    half7 <= half_c;
    st7   <= st_c;
    lsb7  <= lsb;
    sg7   <= sg6b;
    zero7 <= zero6b;
  end

endmodule

// ----- rtl/mfdp_back.sv -----
// ----------------------------------------------------------------------------
// mfdp_back
// Lane accumulators, issue scoreboard and reduction sequencer around the FMA.
// ----------------------------------------------------------------------------
module mfdp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  mfdp_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            o_full,
  output logic            o_push,
  output logic [31:0]     o_data
);

  localparam int L = mfdp_pkg::LANES;

  mfdp_pkg::bstate_t state, state_next;

  logic [31:0] lanes [L];
  logic [31:0] rq [L];
  logic [31:0] rq_next [L];
  logic [L-1:0] busy, busy_next;
  logic [3:0]   rc, rc_next;
  logic [2:0]   adds;

  logic issue_item, issue_red, start_red, push_red;

  logic           f_in_valid;
  logic [31:0]    f_a, f_b, f_c;
  mfdp_pkg::tag_t f_in_tag;
  logic           f_valid;
  logic [31:0]    f_res;
  mfdp_pkg::tag_t f_tag;

  always_comb begin
    state_next = state;
    case (state)
      mfdp_pkg::ST_MAC: begin
        if (issue_item && q_item.last) begin
          state_next = mfdp_pkg::ST_DRAIN;
        end
      end
      mfdp_pkg::ST_DRAIN: begin
        if (start_red) begin
          state_next = mfdp_pkg::ST_REDUCE;
        end
      end
      mfdp_pkg::ST_REDUCE: begin
        if (issue_red && (adds == 3'd6)) begin
          state_next = mfdp_pkg::ST_MAC;
        end
      end
      default: state_next = mfdp_pkg::ST_MAC;
    endcase
  end

  always_comb begin
    issue_item = 1'b0;
    issue_red  = 1'b0;
    start_red  = 1'b0;
    case (state)
      mfdp_pkg::ST_MAC:    issue_item = !q_empty && !busy[q_item.lane];
      mfdp_pkg::ST_DRAIN:  start_red  = (busy == '0) && !o_full;
      mfdp_pkg::ST_REDUCE: issue_red  = (rc >= 4'd2);
      default: ;
    endcase
  end

  assign q_pop      = issue_item;
  assign f_in_valid = issue_item || issue_red;
  assign f_a        = issue_red ? rq[0] : q_item.w;
  assign f_b        = issue_red ? mfdp_pkg::ONE_BITS : q_item.act;
  assign f_c        = issue_red ? rq[1] : lanes[q_item.lane];
  assign f_in_tag.red  = issue_red;
  assign f_in_tag.fin  = issue_red && (adds == 3'd6);
  assign f_in_tag.lane = q_item.lane;

  assign push_red = f_valid && f_tag.red && !f_tag.fin;
  assign o_push   = f_valid && f_tag.red && f_tag.fin;
  assign o_data   = f_res;

  mfdp_fma u_fma (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_in_valid),
    .a        (f_a),
    .b        (f_b),
    .c        (f_c),
    .in_tag   (f_in_tag),
    .out_valid(f_valid),
    .res      (f_res),
    .out_tag  (f_tag)
  );

  always_comb begin
    busy_next = busy;
    if (f_valid && !f_tag.red) begin
      busy_next[f_tag.lane] = 1'b0;
    end
    if (issue_item) begin
      busy_next[q_item.lane] = 1'b1;
    end
  end

  always_comb begin
    rq_next = rq;
    rc_next = rc;
    if (issue_red) begin
      for (int i = 0; i < L - 2; i++) begin
        rq_next[i] = rq[i+2];
      end
      rc_next = rc - 4'd2;
    end
    if (push_red) begin
      rq_next[rc_next[2:0]] = f_res;
      rc_next = rc_next + 4'd1;
    end
    if (start_red) begin
      rq_next[0] = lanes[0];
      rq_next[1] = lanes[4];
      rq_next[2] = lanes[2];
      rq_next[3] = lanes[6];
      rq_next[4] = lanes[1];
      rq_next[5] = lanes[5];
      rq_next[6] = lanes[3];
      rq_next[7] = lanes[7];
      rc_next    = 4'd8;
    end
  end

  always_ff @(posedge clk) begin
    rq <= rq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfdp_pkg::ST_MAC;
      busy  <= '0;
      rc    <= '0;
      adds  <= '0;
      for (int i = 0; i < L; i++) begin
        lanes[i] <= '0;
      end
    end else begin
      state <= state_next;
      busy  <= busy_next;
      rc    <= rc_next;
      if (start_red) begin
        adds <= '0;
      end else if (issue_red) begin
        adds <= adds + 3'd1;
      end
      if (start_red) begin
        for (int i = 0; i < L; i++) begin
          lanes[i] <= '0;
        end
      end else if (f_valid && !f_tag.red) begin
        lanes[f_tag.lane] <= f_res;
      end
    end
  end

endmodule

// ----- rtl/mixed_format_dot_product.sv -----
// ----------------------------------------------------------------------------
// mixed_format_dot_product
// Streams weight/activation pairs, returns one single-precision dot product.
// ----------------------------------------------------------------------------
// Input channel: an item (weight_bits, activation_bits, last_element) enters
// on a clock edge with push high and full low. The weight is widened per the
// weight_format register (cfg_valid/cfg_ready/cfg_data, ready is always high;
// write it only while the block is idle).
// Result channel: sum_bits is valid while empty is low and leaves on a clock
// edge with pop high. One result per item marked last_element.
// Throughput: one item per cycle within a dot product. Element t goes to lane
// t mod 8; the 7-stage fused multiply-add pipeline returns a lane's sum just
// in time for its next element. After a last item the back end drains the
// pipeline and runs seven adds through the same pipeline as a three-level
// tree, while the input queue still takes QUEUE_DEPTH items. A stalled result
// receiver only holds the result queue; the next reduction waits for a free
// result slot.
// Reset (synchronous, rst high) clears lanes, lane counter, queues and sets
// weight_format to half precision.
// ----------------------------------------------------------------------------
module mixed_format_dot_product #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] weight_bits,
  input  logic [31:0] activation_bits,
  input  logic        last_element,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] sum_bits
);

  localparam int ItemW = $bits(mfdp_pkg::item_t);

  mfdp_pkg::item_t f_item;
  mfdp_pkg::item_t b_item;
  logic            f_push;
  logic            b_empty;
  logic            b_pop;
  logic            o_full;
  logic            o_push;
  logic [31:0]     o_data;

  mfdp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .push           (push),
    .q_full         (full),
    .weight_bits    (weight_bits),
    .activation_bits(activation_bits),
    .last_element   (last_element),
    .q_push         (f_push),
    .q_item         (f_item)
  );

  mfdp_fifo #(
    .WIDTH(ItemW),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_q (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .din  (f_item),
    .full (full),
    .pop  (b_pop),
    .dout (b_item),
    .empty(b_empty)
  );

  mfdp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(b_empty),
    .q_item (b_item),
    .q_pop  (b_pop),
    .o_full (o_full),
    .o_push (o_push),
    .o_data (o_data)
  );

  mfdp_fifo #(
    .WIDTH(32),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (o_push),
    .din  (o_data),
    .full (o_full),
    .pop  (pop),
    .dout (sum_bits),
    .empty(empty)
  );

endmodule
